[rtl/stcd_pkg.sv]
// Shared constants, types and a lookup function for the seconds-to-calendar-date unit
`default_nettype none

package stcd_pkg;

    typedef logic [3:0] month_t;
    typedef logic [2:0] wkey_t;

    localparam int unsigned STAGES = 18;

    localparam logic [0:0]  REG_EPOCH   = 1'b0;
    localparam logic [21:0] EPOCH_RESET = 22'd2451545;

    localparam logic [16:0] DAY_SECS    = 17'd86400;
    localparam logic [15:0] DAY_RECIP   = 16'd49710;
    localparam logic [22:0] JD_OFFSET   = 23'd32044;

    localparam logic [17:0] CENT_DAYS   = 18'd146097;
    localparam logic [7:0]  CENT_RECIP  = 8'd229;
    localparam logic [10:0] QUAD_DAYS   = 11'd1461;
    localparam logic [7:0]  QUAD_RECIP  = 8'd179;
    localparam logic [7:0]  MONTH_SPAN  = 8'd153;
    localparam logic [3:0]  MONTH_RECIP = 4'd13;
    localparam logic [7:0]  FIFTH_RECIP = 8'd205;

    localparam logic [11:0] HOUR_SECS   = 12'd3600;
    localparam logic [5:0]  HOUR_RECIP  = 6'd36;
    localparam logic [5:0]  MIN_SECS    = 6'd60;
    localparam logic [6:0]  MIN_RECIP   = 7'd68;

    localparam logic [12:0] YEAR_BIAS   = 13'd4800;
    localparam logic [6:0]  CENT_YEARS  = 7'd100;
    localparam logic [6:0]  YEAR_RECIP  = 7'd81;
    localparam logic [3:0]  DOZEN       = 4'd12;
    localparam logic [5:0]  DOZEN_RECIP = 6'd43;
    localparam logic [2:0]  WEEK_DAYS   = 3'd7;
    localparam logic [7:0]  WEEK_RECIP  = 8'd147;
    localparam logic [2:0]  LEAP_ADJ    = 3'd6;

    localparam month_t MONTH_JAN  = 4'd1;
    localparam month_t MONTH_FEB  = 4'd2;
    localparam month_t MONTH_MAR  = 4'd3;
    localparam month_t MONTH_APR  = 4'd4;
    localparam month_t MONTH_MAY  = 4'd5;
    localparam month_t MONTH_JUN  = 4'd6;
    localparam month_t MONTH_JUL  = 4'd7;
    localparam month_t MONTH_AUG  = 4'd8;
    localparam month_t MONTH_SEP  = 4'd9;
    localparam month_t MONTH_OCT  = 4'd10;
    localparam month_t MONTH_NOV  = 4'd11;
    localparam month_t MONTH_DEC  = 4'd12;
    localparam month_t MONTH_LATE = 4'd10;
    localparam month_t MONTH_SHIFT_UP   = 4'd3;
    localparam month_t MONTH_SHIFT_DOWN = 4'd9;

    function automatic wkey_t month_key(input month_t m);
        wkey_t k;
        case (m)
            MONTH_JAN: k = 3'd6;
            MONTH_FEB: k = 3'd2;
            MONTH_MAR: k = 3'd2;
            MONTH_APR: k = 3'd5;
            MONTH_MAY: k = 3'd0;
            MONTH_JUN: k = 3'd3;
            MONTH_JUL: k = 3'd5;
            MONTH_AUG: k = 3'd1;
            MONTH_SEP: k = 3'd4;
            MONTH_OCT: k = 3'd6;
            MONTH_NOV: k = 3'd2;
            MONTH_DEC: k = 3'd4;
            default:   k = 3'd6;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[rtl/seconds_to_calendar_date_unit.sv]
// Top level of the seconds-to-calendar-date unit: an 18-stage conversion pipeline
// Converts a 32-bit seconds count since a configurable epoch (given as a Julian day
// number, APB register at byte address 0) into Gregorian year, month, day, time of
// day and weekday. A request is taken every cycle while in_stall is low; its result is
// offered at the output once it has passed through every stage. Most divisions are by a
// constant: a reciprocal multiply gives a quotient estimate, the next stage forms the
// remainder and the stage after that applies a single correction step. The chain of
// day, century, four-year, month, two-digit-year and weekday steps, three stages each,
// sets the depth of 18 stages. When a finished result is stalled at the output the
// whole pipeline holds, so in_stall follows out_stall while out_valid is high. The
// weekday is correct for years 2000 to 2099.
`default_nettype none

module seconds_to_calendar_date_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] seconds_count,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [12:0] year,
    output logic      [3:0]  month,
    output logic      [4:0]  day_of_month,
    output logic      [4:0]  hour,
    output logic      [5:0]  minute,
    output logic      [5:0]  second,
    output logic      [2:0]  weekday
);

    localparam int unsigned LAST = stcd_pkg::STAGES - 1;

    logic [21:0]                    epoch_reg;
    logic [stcd_pkg::STAGES-1:0]    v_reg;
    logic                           advance;
    logic                           cfg_write;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == stcd_pkg::REG_EPOCH);
    assign prdata    = (paddr[2] == stcd_pkg::REG_EPOCH) ? {10'd0, epoch_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg <= stcd_pkg::EPOCH_RESET;
        end
        else if (cfg_write)
        begin
            epoch_reg <= pwdata[21:0];
        end
    end

    // Pipeline control
    assign advance   = !(v_reg[LAST] && out_stall);
    assign in_stall  = !advance;
    assign out_valid = v_reg[LAST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[LAST-1:0], in_valid};
        end
    end

    // Stage 1: whole-day quotient estimate
    logic [31:0] s1_secs_reg;
    logic [15:0] s1_dq_reg, s1_dq_next;
    logic [47:0] day_prod;
    assign day_prod   = 48'(seconds_count) * 48'(stcd_pkg::DAY_RECIP);
    assign s1_dq_next = day_prod[47:32];

    // Stage 2: day remainder
    logic [15:0] s2_dq_reg;
    logic [17:0] s2_dr_reg, s2_dr_next;
    logic [32:0] dq_mul;
    assign dq_mul     = 33'(s1_dq_reg) * 33'(stcd_pkg::DAY_SECS);
    assign s2_dr_next = s1_secs_reg[17:0] - dq_mul[17:0];

    // Stage 3: correct days, form Julian day number and time of day
    logic [22:0] s3_jd_reg, s3_jd_next;
    logic [16:0] s3_tod_reg, s3_tod_next;
    logic        dr_wrap;
    logic [15:0] days;
    logic [17:0] dr_fix;
    assign dr_wrap     = (s2_dr_reg >= 18'(stcd_pkg::DAY_SECS));
    assign days        = s2_dq_reg + 16'(dr_wrap);
    assign dr_fix      = dr_wrap ? (s2_dr_reg - 18'(stcd_pkg::DAY_SECS)) : s2_dr_reg;
    assign s3_tod_next = dr_fix[16:0];
    assign s3_jd_next  = 23'(days) + stcd_pkg::JD_OFFSET + 23'(epoch_reg);

    // Stage 4: 400-year and hour quotient estimates
    logic [22:0] s4_jd_reg;
    logic [6:0]  s4_cq_reg, s4_cq_next;
    logic [16:0] s4_tod_reg;
    logic [4:0]  s4_hq_reg, s4_hq_next;
    logic [32:0] cent_prod;
    logic [22:0] hq_prod;
    assign cent_prod  = 33'({s3_jd_reg, 2'b11}) * 33'(stcd_pkg::CENT_RECIP);
    assign s4_cq_next = cent_prod[31:25];
    assign hq_prod    = 23'(s3_tod_reg) * 23'(stcd_pkg::HOUR_RECIP);
    assign s4_hq_next = hq_prod[21:17];

    // Stage 5: 400-year and hour remainders
    logic [6:0]  s5_cq_reg;
    logic [18:0] s5_cr_reg, s5_cr_next;
    logic [4:0]  s5_hq_reg;
    logic [12:0] s5_hr_reg, s5_hr_next;
    logic [24:0] cq_mul;
    logic [16:0] hq_mul;
    assign cq_mul     = 25'(s4_cq_reg) * 25'(stcd_pkg::CENT_DAYS);
    assign s5_cr_next = {s4_jd_reg[16:0], 2'b11} - cq_mul[18:0];
    assign hq_mul     = 17'(s4_hq_reg) * 17'(stcd_pkg::HOUR_SECS);
    assign s5_hr_next = s4_tod_reg[12:0] - hq_mul[12:0];

    // Stage 6: correct century and hour
    logic [6:0]  s6_cent_reg, s6_cent_next;
    logic [15:0] s6_rem_reg, s6_rem_next;
    logic [4:0]  s6_hour_reg, s6_hour_next;
    logic [11:0] s6_rm_reg, s6_rm_next;
    logic        cr_wrap, hr_wrap;
    logic [18:0] cr_fix;
    logic [12:0] hr_fix;
    assign cr_wrap      = (s5_cr_reg >= 19'(stcd_pkg::CENT_DAYS));
    assign s6_cent_next = s5_cq_reg + 7'(cr_wrap);
    assign cr_fix       = cr_wrap ? (s5_cr_reg - 19'(stcd_pkg::CENT_DAYS)) : s5_cr_reg;
    assign s6_rem_next  = cr_fix[17:2];
    assign hr_wrap      = (s5_hr_reg >= 13'(stcd_pkg::HOUR_SECS));
    assign s6_hour_next = s5_hq_reg + 5'(hr_wrap);
    assign hr_fix       = hr_wrap ? (s5_hr_reg - 13'(stcd_pkg::HOUR_SECS)) : s5_hr_reg;
    assign s6_rm_next   = hr_fix[11:0];

    // Stage 7: 4-year and minute quotient estimates
    logic [6:0]  s7_cent_reg;
    logic [15:0] s7_rem_reg;
    logic [6:0]  s7_yq_reg, s7_yq_next;
    logic [4:0]  s7_hour_reg;
    logic [11:0] s7_rm_reg;
    logic [5:0]  s7_mq_reg, s7_mq_next;
    logic [25:0] yq_prod;
    logic [18:0] mq_prod;
    assign yq_prod    = 26'({s6_rem_reg, 2'b11}) * 26'(stcd_pkg::QUAD_RECIP);
    assign s7_yq_next = yq_prod[24:18];
    assign mq_prod    = 19'(s6_rm_reg) * 19'(stcd_pkg::MIN_RECIP);
    assign s7_mq_next = mq_prod[17:12];

    // Stage 8: 4-year and minute remainders
    logic [6:0]  s8_cent_reg;
    logic [6:0]  s8_yq_reg;
    logic [11:0] s8_yr_reg, s8_yr_next;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_mq_reg;
    logic [6:0]  s8_mr_reg, s8_mr_next;
    logic [17:0] yq_mul;
    logic [11:0] mq_mul;
    assign yq_mul     = 18'(s7_yq_reg) * 18'(stcd_pkg::QUAD_DAYS);
    assign s8_yr_next = {s7_rem_reg[9:0], 2'b11} - yq_mul[11:0];
    assign mq_mul     = 12'(s7_mq_reg) * 12'(stcd_pkg::MIN_SECS);
    assign s8_mr_next = s7_rm_reg[6:0] - mq_mul[6:0];

    // Stage 9: correct year in cycle, minute and second
    logic [6:0]  s9_cent_reg;
    logic [6:0]  s9_yic_reg, s9_yic_next;
    logic [8:0]  s9_rem2_reg, s9_rem2_next;
    logic [4:0]  s9_hour_reg;
    logic [5:0]  s9_minute_reg, s9_minute_next;
    logic [5:0]  s9_second_reg, s9_second_next;
    logic        yr_wrap, mr_wrap;
    logic [11:0] yr_fix;
    logic [6:0]  mr_fix;
    assign yr_wrap        = (s8_yr_reg >= 12'(stcd_pkg::QUAD_DAYS));
    assign s9_yic_next    = s8_yq_reg + 7'(yr_wrap);
    assign yr_fix         = yr_wrap ? (s8_yr_reg - 12'(stcd_pkg::QUAD_DAYS)) : s8_yr_reg;
    assign s9_rem2_next   = yr_fix[10:2];
    assign mr_wrap        = (s8_mr_reg >= 7'(stcd_pkg::MIN_SECS));
    assign s9_minute_next = s8_mq_reg + 6'(mr_wrap);
    assign mr_fix         = mr_wrap ? (s8_mr_reg - 7'(stcd_pkg::MIN_SECS)) : s8_mr_reg;
    assign s9_second_next = mr_fix[5:0];

    // Stage 10: month quotient estimate
    logic [6:0]  s10_cent_reg;
    logic [6:0]  s10_yic_reg;
    logic [10:0] s10_t3_reg, s10_t3_next;
    logic [3:0]  s10_mmq_reg, s10_mmq_next;
    logic [4:0]  s10_hour_reg;
    logic [5:0]  s10_minute_reg;
    logic [5:0]  s10_second_reg;
    logic [14:0] mmq_prod;
    assign s10_t3_next  = {s9_rem2_reg[8:0], 2'b00} + 11'(s9_rem2_reg) + 11'd2;
    assign mmq_prod     = 15'(s10_t3_next) * 15'(stcd_pkg::MONTH_RECIP);
    assign s10_mmq_next = mmq_prod[14:11];

    // Stage 11: month remainder
    logic [6:0]  s11_cent_reg;
    logic [6:0]  s11_yic_reg;
    logic [3:0]  s11_mmq_reg;
    logic [8:0]  s11_mmr_reg, s11_mmr_next;
    logic [4:0]  s11_hour_reg;
    logic [5:0]  s11_minute_reg;
    logic [5:0]  s11_second_reg;
    logic [11:0] mmq_mul;
    assign mmq_mul      = 12'(s10_mmq_reg) * 12'(stcd_pkg::MONTH_SPAN);
    assign s11_mmr_next = s10_t3_reg[8:0] - mmq_mul[8:0];

    // Stage 12: calendar year, month and day
    logic [12:0]           s12_year_reg, s12_year_next;
    stcd_pkg::month_t      s12_month_reg, s12_month_next;
    logic [4:0]            s12_day_reg, s12_day_next;
    logic [4:0]            s12_hour_reg;
    logic [5:0]            s12_minute_reg;
    logic [5:0]            s12_second_reg;
    logic                  mmr_wrap, late;
    logic [3:0]            mm;
    logic [8:0]            mmr_fix;
    logic [15:0]           day_prod5;
    logic [13:0]           cent_years;
    assign mmr_wrap       = (s11_mmr_reg >= 9'(stcd_pkg::MONTH_SPAN));
    assign mm             = s11_mmq_reg + 4'(mmr_wrap);
    assign mmr_fix        = mmr_wrap ? (s11_mmr_reg - 9'(stcd_pkg::MONTH_SPAN)) : s11_mmr_reg;
    assign late           = (mm >= stcd_pkg::MONTH_LATE);
    assign s12_month_next = late ? (mm - stcd_pkg::MONTH_SHIFT_DOWN)
                                 : (mm + stcd_pkg::MONTH_SHIFT_UP);
    assign cent_years     = 14'(s11_cent_reg) * 14'(stcd_pkg::CENT_YEARS);
    assign s12_year_next  = cent_years[12:0] + 13'(s11_yic_reg) + 13'(late)
                            - stcd_pkg::YEAR_BIAS;
    assign day_prod5      = 16'(mmr_fix[7:0]) * 16'(stcd_pkg::FIFTH_RECIP);
    assign s12_day_next   = day_prod5[14:10] + 5'd1;

    // Stage 13: century-of-year quotient estimate
    logic [12:0]           s13_year_reg;
    logic [6:0]            s13_y2q_reg, s13_y2q_next;
    stcd_pkg::month_t      s13_month_reg;
    logic [4:0]            s13_day_reg;
    logic [4:0]            s13_hour_reg;
    logic [5:0]            s13_minute_reg;
    logic [5:0]            s13_second_reg;
    logic [19:0]           y2_prod;
    assign y2_prod      = 20'(s12_year_reg) * 20'(stcd_pkg::YEAR_RECIP);
    assign s13_y2q_next = y2_prod[19:13];

    // Stage 14: two-digit year remainder
    logic [12:0]           s14_year_reg;
    logic [7:0]            s14_yr2_reg, s14_yr2_next;
    stcd_pkg::month_t      s14_month_reg;
    logic [4:0]            s14_day_reg;
    logic [4:0]            s14_hour_reg;
    logic [5:0]            s14_minute_reg;
    logic [5:0]            s14_second_reg;
    logic [13:0]           y2q_mul;
    assign y2q_mul      = 14'(s13_y2q_reg) * 14'(stcd_pkg::CENT_YEARS);
    assign s14_yr2_next = s13_year_reg[7:0] - y2q_mul[7:0];

    // Stage 15: two-digit year and its dozens
    logic [12:0]           s15_year_reg;
    logic [6:0]            s15_y2_reg, s15_y2_next;
    logic [3:0]            s15_q12_reg, s15_q12_next;
    stcd_pkg::month_t      s15_month_reg;
    logic [4:0]            s15_day_reg;
    logic [4:0]            s15_hour_reg;
    logic [5:0]            s15_minute_reg;
    logic [5:0]            s15_second_reg;
    logic                  yr2_wrap;
    logic [7:0]            yr2_fix;
    logic [12:0]           q12_prod;
    assign yr2_wrap     = (s14_yr2_reg >= 8'(stcd_pkg::CENT_YEARS));
    assign yr2_fix      = yr2_wrap ? (s14_yr2_reg - 8'(stcd_pkg::CENT_YEARS)) : s14_yr2_reg;
    assign s15_y2_next  = yr2_fix[6:0];
    assign q12_prod     = 13'(s15_y2_next) * 13'(stcd_pkg::DOZEN_RECIP);
    assign s15_q12_next = q12_prod[12:9];

    // Stage 16: weekday sum
    logic [12:0]           s16_year_reg;
    logic [6:0]            s16_sum_reg, s16_sum_next;
    stcd_pkg::month_t      s16_month_reg;
    logic [4:0]            s16_day_reg;
    logic [4:0]            s16_hour_reg;
    logic [5:0]            s16_minute_reg;
    logic [5:0]            s16_second_reg;
    logic [7:0]            q12_mul;
    logic [3:0]            m12;
    logic                  leap_early;

    always_comb
    begin
        q12_mul    = 8'(s15_q12_reg) * 8'(stcd_pkg::DOZEN);
        m12        = s15_y2_reg[3:0] - q12_mul[3:0];
        leap_early = (s15_y2_reg[1:0] == 2'b00)
                     && (s15_month_reg inside {stcd_pkg::MONTH_JAN, stcd_pkg::MONTH_FEB});
        s16_sum_next = 7'(s15_q12_reg) + 7'(m12) + 7'(m12[3:2])
                       + 7'(stcd_pkg::month_key(s15_month_reg))
                       + (leap_early ? 7'(stcd_pkg::LEAP_ADJ) : 7'd0)
                       + 7'(s15_day_reg);
    end

    // Stage 17: week quotient
    logic [12:0]           s17_year_reg;
    logic [6:0]            s17_sum_reg;
    logic [3:0]            s17_q7_reg, s17_q7_next;
    stcd_pkg::month_t      s17_month_reg;
    logic [4:0]            s17_day_reg;
    logic [4:0]            s17_hour_reg;
    logic [5:0]            s17_minute_reg;
    logic [5:0]            s17_second_reg;
    logic [14:0]           q7_prod;
    assign q7_prod     = 15'(s16_sum_reg) * 15'(stcd_pkg::WEEK_RECIP);
    assign s17_q7_next = q7_prod[13:10];

    // Stage 18: weekday and output register
    logic [12:0]           year_reg;
    stcd_pkg::month_t      month_reg;
    logic [4:0]            day_reg;
    logic [4:0]            hour_reg;
    logic [5:0]            minute_reg;
    logic [5:0]            second_reg;
    logic [2:0]            weekday_reg, weekday_next;
    logic [6:0]            q7_mul;
    logic [6:0]            wk_rem;
    assign q7_mul       = 7'(s17_q7_reg) * 7'(stcd_pkg::WEEK_DAYS);
    assign wk_rem       = s17_sum_reg - q7_mul;
    assign weekday_next = wk_rem[2:0];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_secs_reg    <= seconds_count;
            s1_dq_reg      <= s1_dq_next;

            s2_dq_reg      <= s1_dq_reg;
            s2_dr_reg      <= s2_dr_next;

            s3_jd_reg      <= s3_jd_next;
            s3_tod_reg     <= s3_tod_next;

            s4_jd_reg      <= s3_jd_reg;
            s4_cq_reg      <= s4_cq_next;
            s4_tod_reg     <= s3_tod_reg;
            s4_hq_reg      <= s4_hq_next;

            s5_cq_reg      <= s4_cq_reg;
            s5_cr_reg      <= s5_cr_next;
            s5_hq_reg      <= s4_hq_reg;
            s5_hr_reg      <= s5_hr_next;

            s6_cent_reg    <= s6_cent_next;
            s6_rem_reg     <= s6_rem_next;
            s6_hour_reg    <= s6_hour_next;
            s6_rm_reg      <= s6_rm_next;

            s7_cent_reg    <= s6_cent_reg;
            s7_rem_reg     <= s6_rem_reg;
            s7_yq_reg      <= s7_yq_next;
            s7_hour_reg    <= s6_hour_reg;
            s7_rm_reg      <= s6_rm_reg;
            s7_mq_reg      <= s7_mq_next;

            s8_cent_reg    <= s7_cent_reg;
            s8_yq_reg      <= s7_yq_reg;
            s8_yr_reg      <= s8_yr_next;
            s8_hour_reg    <= s7_hour_reg;
            s8_mq_reg      <= s7_mq_reg;
            s8_mr_reg      <= s8_mr_next;

            s9_cent_reg    <= s8_cent_reg;
            s9_yic_reg     <= s9_yic_next;
            s9_rem2_reg    <= s9_rem2_next;
            s9_hour_reg    <= s8_hour_reg;
            s9_minute_reg  <= s9_minute_next;
            s9_second_reg  <= s9_second_next;

            s10_cent_reg   <= s9_cent_reg;
            s10_yic_reg    <= s9_yic_reg;
            s10_t3_reg     <= s10_t3_next;
            s10_mmq_reg    <= s10_mmq_next;
            s10_hour_reg   <= s9_hour_reg;
            s10_minute_reg <= s9_minute_reg;
            s10_second_reg <= s9_second_reg;

            s11_cent_reg   <= s10_cent_reg;
            s11_yic_reg    <= s10_yic_reg;
            s11_mmq_reg    <= s10_mmq_reg;
            s11_mmr_reg    <= s11_mmr_next;
            s11_hour_reg   <= s10_hour_reg;
            s11_minute_reg <= s10_minute_reg;
            s11_second_reg <= s10_second_reg;

            s12_year_reg   <= s12_year_next;
            s12_month_reg  <= s12_month_next;
            s12_day_reg    <= s12_day_next;
            s12_hour_reg   <= s11_hour_reg;
            s12_minute_reg <= s11_minute_reg;
            s12_second_reg <= s11_second_reg;

            s13_year_reg   <= s12_year_reg;
            s13_y2q_reg    <= s13_y2q_next;
            s13_month_reg  <= s12_month_reg;
            s13_day_reg    <= s12_day_reg;
            s13_hour_reg   <= s12_hour_reg;
            s13_minute_reg <= s12_minute_reg;
            s13_second_reg <= s12_second_reg;

            s14_year_reg   <= s13_year_reg;
            s14_yr2_reg    <= s14_yr2_next;
            s14_month_reg  <= s13_month_reg;
            s14_day_reg    <= s13_day_reg;
            s14_hour_reg   <= s13_hour_reg;
            s14_minute_reg <= s13_minute_reg;
            s14_second_reg <= s13_second_reg;

            s15_year_reg   <= s14_year_reg;
            s15_y2_reg     <= s15_y2_next;
            s15_q12_reg    <= s15_q12_next;
            s15_month_reg  <= s14_month_reg;
            s15_day_reg    <= s14_day_reg;
            s15_hour_reg   <= s14_hour_reg;
            s15_minute_reg <= s14_minute_reg;
            s15_second_reg <= s14_second_reg;

            s16_year_reg   <= s15_year_reg;
            s16_sum_reg    <= s16_sum_next;
            s16_month_reg  <= s15_month_reg;
            s16_day_reg    <= s15_day_reg;
            s16_hour_reg   <= s15_hour_reg;
            s16_minute_reg <= s15_minute_reg;
            s16_second_reg <= s15_second_reg;

            s17_year_reg   <= s16_year_reg;
            s17_sum_reg    <= s16_sum_reg;
            s17_q7_reg     <= s17_q7_next;
            s17_month_reg  <= s16_month_reg;
            s17_day_reg    <= s16_day_reg;
            s17_hour_reg   <= s16_hour_reg;
            s17_minute_reg <= s16_minute_reg;
            s17_second_reg <= s16_second_reg;

            year_reg       <= s17_year_reg;
            month_reg      <= s17_month_reg;
            day_reg        <= s17_day_reg;
            hour_reg       <= s17_hour_reg;
            minute_reg     <= s17_minute_reg;
            second_reg     <= s17_second_reg;
            weekday_reg    <= weekday_next;
        end
    end

    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = day_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign weekday      = weekday_reg;

endmodule

`default_nettype wire

[rtl/stcd_checker.sv]
// Port-level checker for the seconds-to-calendar-date unit and its bind
`default_nettype none

module stcd_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [12:0] year,
    input wire logic [3:0]  month,
    input wire logic [4:0]  day_of_month,
    input wire logic [4:0]  hour,
    input wire logic [5:0]  minute,
    input wire logic [5:0]  second,
    input wire logic [2:0]  weekday
);

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(year) && $stable(month)
            && $stable(day_of_month) && $stable(weekday) && $stable(second)))
        else $error("stalled result changed");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month >= 4'd1 && month <= 4'd12
            && day_of_month >= 5'd1 && weekday <= 3'd6))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
        else $error("time field out of range");

endmodule

bind seconds_to_calendar_date_unit stcd_checker u_stcd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .weekday      (weekday)
);

`default_nettype wire
